[design/btb_two_level_branch_predictor_top_macros.svh]
// Assertion macros shared by the checker of the branch predictor.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef BTB_TWO_LEVEL_BRANCH_PREDICTOR_TOP_MACROS_SVH
`define BTB_TWO_LEVEL_BRANCH_PREDICTOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BTBP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define BTBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Delayed implication, checked outside reset.
`define BTBP_ASSERT_LATER(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed");

`endif

[design/btbp_pkg.sv]
// Package of the branch predictor: stream widths, register indexes, parameter defaults, share modes, commands.
// Used by the top level and the checker.
package btbp_pkg;

    localparam int TDATA_W = 104;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 5;

    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DEF_MAX_HISTORY = 8;
    localparam int DEF_MAX_TAG = 30;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_LEN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_HIST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_TABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHARE_MODE   = 3'd6;

    localparam logic [1:0] SHARE_PC2  = 2'd1;
    localparam logic [1:0] SHARE_PC16 = 2'd2;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

endpackage

[design/btbp_ctr_ram.sv]
// Counter row memory of the branch predictor: one write port, one registered read port.
// Depends on nothing outside this file.
module btbp_ctr_ram #(
    parameter int ROWS = 33,
    parameter int ROW_W = 512,
    parameter int AW = 6
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [ROW_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [ROW_W-1:0] wr_data
);

    logic [ROW_W-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/btb_two_level_branch_predictor_top.sv]
// Top level of the branch target buffer with two-level predictor.
// Depends on btbp_pkg and btbp_ctr_ram.
//
//  channel  | signals                         | direction
//  ---------+---------------------------------+----------
//  s_axis   | tvalid tready tdata tuser       | in
//  m_axis   | tvalid tready tdata             | out
//  cfg      | valid ready index data          | in
//
// On acceptance an item reads its counter row from the memory; in the execute
// step an update then modifies one counter and writes the row back. The next
// item is taken once the execute step is done; a held result stalls that
// step. Reset clears control state, valid bits and histories; counter rows
// marked invalid read as the default state, so no clearing pass is needed.
// Configuration writes reinitialize the same way.
module btb_two_level_branch_predictor_top #(
    parameter int MAX_ENTRIES = btbp_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_HISTORY = btbp_pkg::DEF_MAX_HISTORY,
    parameter int MAX_TAG = btbp_pkg::DEF_MAX_TAG
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // pc[31:0], target_pc[63:32], taken[64], predicted_dst[96:65], zero fill
    input  logic [btbp_pkg::TDATA_W-1:0] s_axis_tdata,
    // command[0]
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // predict_taken[0], predicted_target[32:1], flush[33], branch_count[65:34],
    // flush_count[97:66], zero fill
    output logic [btbp_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [btbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btbp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import btbp_pkg::*;

    localparam int KMAX = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int IDX_W = (KMAX > 0) ? KMAX : 1;
    localparam int HW = MAX_HISTORY;
    localparam int TAG_W = (MAX_TAG > 0) ? MAX_TAG : 1;
    localparam int ROWS = MAX_ENTRIES + 1;
    localparam int RAW = $clog2(ROWS);
    localparam int ROW_N = 1 << HW;
    localparam int ROW_W = 2 * ROW_N;

    typedef enum logic {S_IDLE, S_EXEC} state_t;
    state_t state_reg;

    // configuration registers
    logic [2:0] index_bits_reg;
    logic [3:0] history_len_reg;
    logic [4:0] tag_len_reg;
    logic [1:0] default_state_reg;
    logic       ghm_reg;
    logic       gtm_reg;
    logic [1:0] share_reg;

    // entry table (flip-flops)
    logic              entry_valid_reg [MAX_ENTRIES];
    logic [TAG_W-1:0]  entry_tag_reg [MAX_ENTRIES];
    logic [31:0]       entry_target_reg [MAX_ENTRIES];
    logic [HW-1:0]     entry_hist_reg [MAX_ENTRIES];
    logic [HW-1:0]     shared_hist_reg;
    logic              row_valid_reg [ROWS];
    logic [31:0]       update_total_reg;
    logic [31:0]       flush_total_reg;

    // item held between the two steps
    logic              cmd_reg;
    logic              hit_reg;
    logic              clear_row_reg;
    logic [HW-1:0]     ci_reg;
    logic [RAW-1:0]    addr_reg;
    logic [31:0]       tgt_reg;
    logic [31:0]       pc4_reg;
    logic              flush_reg;
    logic              taken_reg;

    logic                 out_valid_reg;
    logic [TDATA_W-1:0]   out_data_reg;

    // input fields
    logic        in_cmd;
    logic [31:0] in_pc;
    logic [31:0] in_target;
    logic        in_taken;
    logic [31:0] in_pdst;

    logic           in_xfer;
    logic           cfg_xfer;
    logic           exec_go;
    logic [3:0]     eff_ib;
    logic [3:0]     eff_hb;
    logic [4:0]     eff_tl;
    logic [29:0]    word;
    logic [29:0]    word_sh;
    logic [IDX_W-1:0] idx_mask;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag_mask;
    logic [TAG_W-1:0] tag;
    logic [HW-1:0]  hmask;
    logic           hit;
    logic           alloc;
    logic [HW-1:0]  hist_sel;
    logic [HW-1:0]  hist_ci;
    logic [HW:0]    hist_shift;
    logic [HW-1:0]  hist_new;
    logic [HW-1:0]  ci;
    logic [RAW-1:0] row_addr;
    logic           flush;

    logic [ROW_W-1:0] rd_data;
    logic [ROW_W-1:0] dflt_row;
    logic [ROW_W-1:0] row_cur;
    logic [ROW_W-1:0] row_new;
    logic [1:0]       ctr;
    logic [1:0]       ctr_new;
    logic             ptaken;
    logic [31:0]      ptarget;

    assign in_cmd    = s_axis_tuser;
    assign in_pc     = s_axis_tdata[31:0];
    assign in_target = s_axis_tdata[63:32];
    assign in_taken  = s_axis_tdata[64];
    assign in_pdst   = s_axis_tdata[96:65];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_xfer      = cfg_valid && cfg_ready;
    assign exec_go       = (state_reg == S_EXEC) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // clip oversized register values and decode the pc
    always_comb
    begin
        eff_ib = (int'(index_bits_reg) > KMAX) ? 4'(KMAX) : {1'b0, index_bits_reg};
        eff_hb = (int'(history_len_reg) > MAX_HISTORY) ? 4'(MAX_HISTORY) : history_len_reg;
        eff_tl = (int'(tag_len_reg) > MAX_TAG) ? 5'(MAX_TAG) : tag_len_reg;
        word = in_pc[31:2];
        word_sh = word >> eff_ib;
        for (int i = 0; i < IDX_W; i++)
        begin
            idx_mask[i] = (i < int'(eff_ib));
        end
        for (int i = 0; i < TAG_W; i++)
        begin
            tag_mask[i] = (i < int'(eff_tl));
        end
        for (int i = 0; i < HW; i++)
        begin
            hmask[i] = (i < int'(eff_hb));
        end
        idx = word[IDX_W-1:0] & idx_mask;
        tag = word_sh[TAG_W-1:0] & tag_mask;
    end

    // look up the entry and form the counter index
    always_comb
    begin
        hit = entry_valid_reg[idx] && (entry_tag_reg[idx] == tag);
        alloc = (in_cmd == CMD_UPDATE) && !hit;
        hist_sel = ghm_reg ? shared_hist_reg : entry_hist_reg[idx];
        // a fresh local entry starts from an empty history
        hist_ci = (alloc && !ghm_reg) ? '0 : hist_sel;
        if (gtm_reg && share_reg == SHARE_PC2)
        begin
            ci = (in_pc[2 +: HW] ^ hist_ci) & hmask;
        end
        else if (gtm_reg && share_reg == SHARE_PC16)
        begin
            ci = (in_pc[16 +: HW] ^ hist_ci) & hmask;
        end
        else
        begin
            ci = hist_ci & hmask;
        end
        hist_shift = {hist_ci, in_taken};
        hist_new = hist_shift[HW-1:0] & hmask;
        row_addr = gtm_reg ? RAW'(MAX_ENTRIES) : RAW'(idx);
        flush = (in_taken && in_pdst == in_pc + 32'd4) || (!in_taken && in_pdst == in_target);
    end

    // pick the counter in the row just read
    always_comb
    begin
        dflt_row = {ROW_N{default_state_reg}};
        row_cur = (row_valid_reg[addr_reg] && !clear_row_reg) ? rd_data : dflt_row;
        ctr = row_cur[{ci_reg, 1'b0} +: 2];
        ptaken = (cmd_reg == CMD_PREDICT) && hit_reg && ctr[1];
        ptarget = (cmd_reg == CMD_UPDATE) ? 32'd0 : (ptaken ? tgt_reg : pc4_reg);
    end

    // step the counter toward the resolved outcome, saturating at both ends
    always_comb
    begin
        if (taken_reg && ctr != 2'd3)
        begin
            ctr_new = ctr + 2'd1;
        end
        else if (!taken_reg && ctr != 2'd0)
        begin
            ctr_new = ctr - 2'd1;
        end
        else
        begin
            ctr_new = ctr;
        end
    end

    always_comb
    begin
        row_new = row_cur;
        row_new[{ci_reg, 1'b0} +: 2] = ctr_new;
    end

    btbp_ctr_ram #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W),
        .AW    (RAW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (in_xfer),
        .rd_addr (row_addr),
        .rd_data (rd_data),
        .wr_en   (exec_go && cmd_reg == CMD_UPDATE),
        .wr_addr (addr_reg),
        .wr_data (row_new)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg    <= 3'd0;
            history_len_reg   <= 4'd1;
            tag_len_reg       <= 5'd0;
            default_state_reg <= 2'd1;
            ghm_reg           <= 1'b0;
            gtm_reg           <= 1'b0;
            share_reg         <= 2'd0;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                REG_INDEX_BITS:   index_bits_reg    <= cfg_data[2:0];
                REG_HISTORY_LEN:  history_len_reg   <= cfg_data[3:0];
                REG_TAG_LEN:      tag_len_reg       <= cfg_data;
                REG_DEFAULT:      default_state_reg <= cfg_data[1:0];
                REG_GLOBAL_HIST:  ghm_reg           <= cfg_data[0];
                REG_GLOBAL_TABLE: gtm_reg           <= cfg_data[0];
                REG_SHARE_MODE:   share_reg         <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // a write to a listed register reinitializes the tables
    logic cfg_reinit;
    assign cfg_reinit = cfg_xfer && (cfg_index <= REG_SHARE_MODE);

    // valid bits, histories and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
                entry_hist_reg[i]  <= '0;
            end
            for (int i = 0; i < ROWS; i++)
            begin
                row_valid_reg[i] <= 1'b0;
            end
            shared_hist_reg  <= '0;
            update_total_reg <= 32'd0;
            flush_total_reg  <= 32'd0;
        end
        else if (cfg_reinit)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
                entry_hist_reg[i]  <= '0;
            end
            for (int i = 0; i < ROWS; i++)
            begin
                row_valid_reg[i] <= 1'b0;
            end
            shared_hist_reg <= '0;
        end
        else
        begin
            if (in_xfer && in_cmd == CMD_UPDATE)
            begin
                update_total_reg <= update_total_reg + 32'd1;
                if (flush)
                begin
                    flush_total_reg <= flush_total_reg + 32'd1;
                end
                entry_valid_reg[idx] <= 1'b1;
                if (ghm_reg)
                begin
                    shared_hist_reg <= hist_new;
                end
                else
                begin
                    entry_hist_reg[idx] <= hist_new;
                end
            end
            if (exec_go && cmd_reg == CMD_UPDATE)
            begin
                row_valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // tag and target are written on allocation only
    always_ff @(posedge clk)
    begin
        if (in_xfer && alloc)
        begin
            entry_tag_reg[idx]    <= tag;
            entry_target_reg[idx] <= in_target;
        end
    end

    // hold the item across the row read
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg       <= in_cmd;
            hit_reg       <= hit;
            clear_row_reg <= alloc && !gtm_reg;
            ci_reg        <= ci;
            addr_reg      <= row_addr;
            tgt_reg       <= entry_target_reg[idx];
            pc4_reg       <= in_pc + 32'd4;
            flush_reg     <= (in_cmd == CMD_UPDATE) && flush;
            taken_reg     <= in_taken;
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (exec_go)
                    begin
                        out_data_reg  <= {6'd0, flush_total_reg, update_total_reg, flush_reg,
                                          ptarget, ptaken};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            // raise on a new result, drop once the held one is taken
            if (exec_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[design/btbp_checker.sv]
// Port-level checker of the branch predictor, bound to the top level.
// Depends on btbp_pkg and the assertion macro header.
`include "btb_two_level_branch_predictor_top_macros.svh"

module btbp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [btbp_pkg::TDATA_W-1:0] s_axis_tdata,
    input logic                         s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [btbp_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [btbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [btbp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import btbp_pkg::*;

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // result stays offered until taken
    `BTBP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // one item in flight: input closes right after a transfer
    `BTBP_ASSERT_NEXT(a_one_in_flight, in_xfer, !s_axis_tready)
    // with the output free, the result is registered once the execute step follows the transfer
    `BTBP_ASSERT_LATER(a_latency, in_xfer && !m_axis_tvalid, m_axis_tvalid)
    // a flush only comes from an update, which never reports a taken prediction
    `BTBP_ASSERT_SAME(a_flush_update, m_axis_tvalid && m_axis_tdata[33], !m_axis_tdata[0])

endmodule

bind btb_two_level_branch_predictor_top btbp_checker u_btbp_checker (.*);
